// ===== src/gnms_pkg.sv =====
// ----------------------------------------------------------------------------
// gnms_pkg
// Shared types and constants for gradient non-max suppression.
// ----------------------------------------------------------------------------
`default_nettype none

package gnms_pkg;

  localparam int MagW  = 15;
  localparam int GradW = 16;
  localparam int CoordW = 12;
  localparam int CfgW  = 13;

  // tan(22.5 deg) in Q16
  localparam logic [14:0] TanQ16 = 15'd27146;

  localparam logic [CfgW-1:0] FrameWidthRst  = 13'd2704;
  localparam logic [CfgW-1:0] FrameHeightRst = 13'd1520;
  localparam int MinFrameSize = 3;

  typedef enum logic [0:0] {
    CfgFrameWidth  = 1'b0,
    CfgFrameHeight = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    Sec0   = 2'd0,
    Sec45  = 2'd1,
    Sec90  = 2'd2,
    Sec135 = 2'd3
  } sector_e;

  typedef struct packed {
    logic [MagW-1:0]         magnitude;
    logic signed [GradW-1:0] grad_x;
    logic signed [GradW-1:0] grad_y;
  } pixel_t;

  typedef struct packed {
    logic [CoordW-1:0] pixel_row;
    logic [CoordW-1:0] pixel_col;
    logic              is_candidate;
    logic              last;
  } result_t;

  // one line-buffer word per column
  typedef struct packed {
    logic [MagW-1:0] upper;
    logic [MagW-1:0] middle;
    logic [1:0]      sector;
  } line_word_t;

endpackage

`default_nettype wire

// ===== src/gnms_stream_if.sv =====
// ----------------------------------------------------------------------------
// gnms_stream_if
// Valid/ready stream channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface gnms_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/gnms_ram.sv =====
// ----------------------------------------------------------------------------
// gnms_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gnms_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/gradient_non_max_suppression.sv =====
// ----------------------------------------------------------------------------
// gradient_non_max_suppression
// Streaming Canny non-maximum suppression over a raster gradient stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless the output stalls it. Each pixel yields
// zero to three result beats: the pixel one row up and one column left is
// decided, a pixel that ends a row also flushes the right-border pixel above
// it, and pixels of the last row are passed out directly as non-edges. Each
// beat beyond the first stalls the input, as does a result not yet taken. The
// first beat of a pixel passes the input register, the line-buffer read plus
// multiply and the result register. Both magnitude rows and the sector row
// live in one RAM word per column, read when a pixel leaves the input
// register and written back one stage later. The line buffer has no clearing
// pass: every column is written on the first row, and words read before that
// never reach a candidate decision.
`default_nettype none

module gradient_non_max_suppression #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [gnms_pkg::CfgW-1:0] cfg_wdata_i,
  gnms_stream_if.sink               pix_i,
  gnms_stream_if.source             res_o
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int SzA = ($clog2(MAX_WIDTH + 1) > gnms_pkg::CfgW) ?
                       $clog2(MAX_WIDTH + 1) : gnms_pkg::CfgW;
  localparam int SZW = ($clog2(MAX_HEIGHT + 1) > SzA) ? $clog2(MAX_HEIGHT + 1) : SzA;
  localparam int MagW = gnms_pkg::MagW;
  localparam int GradW = gnms_pkg::GradW;
  localparam int CoordW = gnms_pkg::CoordW;
  localparam int ProdW = GradW + 15;

  typedef struct packed {
    logic dec;
    logic rend;
    logic lrow;
    logic inner;
  } emit_t;

  // ---------------- configuration ----------------
  logic [gnms_pkg::CfgW-1:0] frame_width_q, frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= gnms_pkg::FrameWidthRst;
      frame_height_q <= gnms_pkg::FrameHeightRst;
    end else if (cfg_we_i) begin
      unique case (gnms_pkg::cfg_idx_e'(cfg_idx_i))
        gnms_pkg::CfgFrameWidth:  frame_width_q  <= cfg_wdata_i;
        gnms_pkg::CfgFrameHeight: frame_height_q <= cfg_wdata_i;
      endcase
    end
  end

  logic [SZW-1:0] w_raw, h_raw, w_eff, h_eff;

  assign w_raw = SZW'(frame_width_q);
  assign h_raw = SZW'(frame_height_q);
  assign w_eff = (w_raw < SZW'(gnms_pkg::MinFrameSize)) ? SZW'(gnms_pkg::MinFrameSize) :
                 (w_raw > SZW'(MAX_WIDTH)) ? SZW'(MAX_WIDTH) : w_raw;
  assign h_eff = (h_raw < SZW'(gnms_pkg::MinFrameSize)) ? SZW'(gnms_pkg::MinFrameSize) :
                 (h_raw > SZW'(MAX_HEIGHT)) ? SZW'(MAX_HEIGHT) : h_raw;

  // ---------------- handshake ----------------
  logic s0_valid_q, s1_valid_q;
  logic [2:0] s2_mask_q;
  logic s2_single, s2_free, s1_adv, s1_free, s0_adv, s0_free, in_acc, out_acc;

  assign s2_single = (s2_mask_q & (s2_mask_q - 3'd1)) == 3'd0;
  assign s2_free   = (s2_mask_q == 3'd0) || (res_o.ready && s2_single);
  assign s1_adv    = s1_valid_q && s2_free;
  assign s1_free   = !s1_valid_q || s2_free;
  assign s0_adv    = s0_valid_q && s1_free;
  assign s0_free   = !s0_valid_q || s1_free;
  assign pix_i.ready = s0_free;
  assign in_acc    = pix_i.valid && s0_free;
  assign out_acc   = res_o.valid && res_o.ready;

  // ---------------- position counters ----------------
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic last_col, last_row;
  emit_t in_emit;

  assign last_col = SZW'(col_q) >= (w_eff - SZW'(1));
  assign last_row = SZW'(row_q) >= (h_eff - SZW'(1));

  always_comb begin
    in_emit.dec   = (row_q != '0) && (col_q != '0);
    in_emit.rend  = (row_q != '0) && last_col;
    in_emit.lrow  = last_row;
    in_emit.inner = (SZW'(row_q) >= SZW'(2)) && (SZW'(row_q) <= h_eff - SZW'(1)) &&
                    (SZW'(col_q) >= SZW'(2)) && (SZW'(col_q) <= w_eff - SZW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // ---------------- stage 0: input register ----------------
  gnms_pkg::pixel_t pin;
  logic [GradW-1:0] in_ax, in_ay;
  logic in_neg;

  assign pin    = pix_i.payload;
  assign in_ax  = pin.grad_x[GradW-1] ? GradW'(-pin.grad_x) : GradW'(pin.grad_x);
  assign in_ay  = pin.grad_y[GradW-1] ? GradW'(-pin.grad_y) : GradW'(pin.grad_y);
  assign in_neg = pin.grad_y[GradW-1] || ((pin.grad_y == '0) && pin.grad_x[GradW-1]);

  logic [MagW-1:0]  s0_mag_q;
  logic [GradW-1:0] s0_ax_q, s0_ay_q;
  logic s0_gzero_q, s0_xzero_q, s0_xpos_q;
  logic [RW-1:0] s0_row_q;
  logic [CW-1:0] s0_col_q;
  emit_t s0_emit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s0_free) begin
      s0_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s0_mag_q   <= pin.magnitude;
      s0_ax_q    <= in_ax;
      s0_ay_q    <= in_ay;
      s0_gzero_q <= (pin.grad_x == '0) && (pin.grad_y == '0);
      s0_xzero_q <= pin.grad_x == '0;
      s0_xpos_q  <= in_neg ? pin.grad_x[GradW-1] : !pin.grad_x[GradW-1];
      s0_row_q   <= row_q;
      s0_col_q   <= col_q;
      s0_emit_q  <= in_emit;
    end
  end

  // ---------------- stage 1: line-buffer read, products ----------------
  logic [ProdW-1:0] s0_tx, s0_ty;

  assign s0_tx = ProdW'(s0_ax_q) * ProdW'(gnms_pkg::TanQ16);
  assign s0_ty = ProdW'(s0_ay_q) * ProdW'(gnms_pkg::TanQ16);

  logic [MagW-1:0]  s1_mag_q;
  logic [GradW-1:0] s1_ax_q, s1_ay_q;
  logic [ProdW-1:0] s1_tx_q, s1_ty_q;
  logic s1_gzero_q, s1_xzero_q, s1_xpos_q;
  logic [RW-1:0] s1_row_q;
  logic [CW-1:0] s1_col_q;
  emit_t s1_emit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_adv) begin
      s1_mag_q   <= s0_mag_q;
      s1_ax_q    <= s0_ax_q;
      s1_ay_q    <= s0_ay_q;
      s1_tx_q    <= s0_tx;
      s1_ty_q    <= s0_ty;
      s1_gzero_q <= s0_gzero_q;
      s1_xzero_q <= s0_xzero_q;
      s1_xpos_q  <= s0_xpos_q;
      s1_row_q   <= s0_row_q;
      s1_col_q   <= s0_col_q;
      s1_emit_q  <= s0_emit_q;
    end
  end

  gnms_pkg::line_word_t ram_rd, ram_wr;
  logic [$bits(gnms_pkg::line_word_t)-1:0] ram_rdata;

  gnms_ram #(
    .Width ($bits(gnms_pkg::line_word_t)),
    .Depth (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (ram_wr),
    .re_i    (s0_adv),
    .raddr_i (s0_col_q),
    .rdata_o (ram_rdata)
  );

  assign ram_rd = gnms_pkg::line_word_t'(ram_rdata);

  // sector pick
  gnms_pkg::sector_e s1_sec;
  logic [31:0] ax_sh, ay_sh, tx_ext, ty_ext;

  assign ax_sh  = {s1_ax_q, 16'd0};
  assign ay_sh  = {s1_ay_q, 16'd0};
  assign tx_ext = 32'(s1_tx_q);
  assign ty_ext = 32'(s1_ty_q);

  always_comb begin
    if (s1_gzero_q) begin
      s1_sec = gnms_pkg::Sec0;
    end else if (s1_xzero_q) begin
      s1_sec = gnms_pkg::Sec90;
    end else if (s1_xpos_q) begin
      if (ay_sh < tx_ext)       s1_sec = gnms_pkg::Sec0;
      else if (ax_sh <= ty_ext) s1_sec = gnms_pkg::Sec90;
      else                      s1_sec = gnms_pkg::Sec45;
    end else begin
      if (ay_sh <= tx_ext)      s1_sec = gnms_pkg::Sec0;
      else if (ax_sh < ty_ext)  s1_sec = gnms_pkg::Sec90;
      else                      s1_sec = gnms_pkg::Sec135;
    end
  end

  always_comb begin
    ram_wr.upper  = ram_rd.middle;
    ram_wr.middle = s1_mag_q;
    ram_wr.sector = s1_sec;
  end

  // 3x3 window: left and center columns of each row; right column comes
  // straight from the line buffer and the input
  logic [MagW-1:0] t1_q, t2_q, m1_q, m2_q, b1_q, b2_q;
  gnms_pkg::sector_e held_sec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q       <= '0;
      t2_q       <= '0;
      m1_q       <= '0;
      m2_q       <= '0;
      b1_q       <= '0;
      b2_q       <= '0;
      held_sec_q <= gnms_pkg::Sec0;
    end else if (s1_adv) begin
      t1_q       <= t2_q;
      t2_q       <= ram_rd.upper;
      m1_q       <= m2_q;
      m2_q       <= ram_rd.middle;
      b1_q       <= b2_q;
      b2_q       <= s1_mag_q;
      held_sec_q <= gnms_pkg::sector_e'(ram_rd.sector);
    end
  end

  logic [MagW-1:0] nb_a, nb_b;
  logic s1_cand;

  always_comb begin
    case (held_sec_q)
      gnms_pkg::Sec0: begin
        nb_a = m1_q;
        nb_b = ram_rd.middle;
      end
      gnms_pkg::Sec45: begin
        nb_a = t1_q;
        nb_b = s1_mag_q;
      end
      gnms_pkg::Sec90: begin
        nb_a = t2_q;
        nb_b = b2_q;
      end
      default: begin
        nb_a = ram_rd.upper;
        nb_b = b1_q;
      end
    endcase
  end

  assign s1_cand = s1_emit_q.inner && (m2_q >= nb_a) && (m2_q >= nb_b);

  // ---------------- stage 2: result register ----------------
  logic [CoordW-1:0] s2_row_q, s2_rm1_q, s2_col_q, s2_cm1_q;
  logic s2_cand_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_mask_q <= 3'd0;
    end else if (s1_adv) begin
      s2_mask_q <= {s1_emit_q.lrow, s1_emit_q.rend, s1_emit_q.dec};
    end else if (out_acc) begin
      s2_mask_q <= s2_mask_q & (s2_mask_q - 3'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_row_q  <= CoordW'(s1_row_q);
      s2_rm1_q  <= CoordW'(s1_row_q - RW'(1));
      s2_col_q  <= CoordW'(s1_col_q);
      s2_cm1_q  <= CoordW'(s1_col_q - CW'(1));
      s2_cand_q <= s1_cand;
    end
  end

  gnms_pkg::result_t res;

  always_comb begin
    res.pixel_row    = s2_mask_q[2:0] == 3'b100 ? s2_row_q : s2_rm1_q;
    res.pixel_col    = s2_mask_q[0] ? s2_cm1_q : s2_col_q;
    res.is_candidate = s2_mask_q[0] && s2_cand_q;
    res.last         = s2_single;
    if (!s2_mask_q[0] && !s2_mask_q[1]) begin
      res.pixel_row = s2_row_q;
    end
  end

  assign res_o.valid   = s2_mask_q != 3'd0;
  assign res_o.payload = res;

endmodule

`default_nettype wire

// ===== src/gnms_checker.sv =====
// ----------------------------------------------------------------------------
// gnms_checker
// Port-level checks on the result stream of gradient non-max suppression.
// ----------------------------------------------------------------------------
`default_nettype none

module gnms_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic [gnms_pkg::CoordW-1:0]   res_row_i,
  input logic [gnms_pkg::CoordW-1:0]   res_col_i,
  input logic                          res_cand_i,
  input logic                          res_last_i
);

  logic                        res_acc;
  logic                        open_q;
  logic [gnms_pkg::CoordW-1:0] prev_row_q, prev_col_q;

  assign res_acc = res_valid_i && res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q     <= 1'b0;
      prev_row_q <= '0;
      prev_col_q <= '0;
    end else if (res_acc) begin
      open_q     <= !res_last_i;
      prev_row_q <= res_row_i;
      prev_col_q <= res_col_i;
    end
  end

  // stalled beat holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_row_i) &&
      $stable(res_col_i) && $stable(res_cand_i) && $stable(res_last_i))
    else $error("result beat changed while stalled");

  // candidates never on the top row or left column
  a_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_cand_i |-> res_row_i != '0 && res_col_i != '0)
    else $error("candidate on frame border");

  // beats of one pixel step right and/or down by at most one
  a_group_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_acc && open_q |->
      (res_col_i == prev_col_q || res_col_i == prev_col_q + 12'd1) &&
      (res_row_i == prev_row_q || res_row_i == prev_row_q + 12'd1) &&
      !(res_col_i == prev_col_q && res_row_i == prev_row_q))
    else $error("beats of one pixel out of order");

endmodule

bind gradient_non_max_suppression gnms_checker u_gnms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_row_i   (res_o.payload.pixel_row),
  .res_col_i   (res_o.payload.pixel_col),
  .res_cand_i  (res_o.payload.is_candidate),
  .res_last_i  (res_o.payload.last)
);

`default_nettype wire
